/* hw/rtl/acmac_pkg.sv */
// Shared types and constants for the AES-CMAC-128 engine.
package acmac_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int AES_ROUNDS  = 10;
    localparam logic [7:0] GF_POLY  = 8'h87;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [0:0] ADDR_KEY_HIGH = 1'b0;
    localparam logic [0:0] ADDR_KEY_LOW  = 1'b1;

    localparam logic [0:0] MODE_ABSORB = 1'b0;
    localparam logic [0:0] MODE_FINISH = 1'b1;

    typedef logic [127:0] block_t;

    // Request to the cipher core and its answer.
    typedef struct packed {
        logic   start;
        block_t text;
    } aes_req_t;

    typedef struct packed {
        logic   done;
        block_t text;
    } aes_rsp_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] s [256];
        s = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return s[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

/* hw/rtl/acmac_aes_core.sv */
// Round-iterative AES-128 encryption core, one round per cycle.
module acmac_aes_core
    import acmac_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  block_t   key,
    input  aes_req_t req,
    output aes_rsp_t rsp
);

    block_t     state_reg, state_next;
    block_t     rkey_reg, rkey_next;
    logic [7:0] rcon_reg, rcon_next;
    logic [3:0] round_reg, round_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;

    block_t     sub_shift, mixed, round_out, next_key;
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [31:0] w0, w1, w2, w3, rot;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            b[i] = state_reg[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*c] = sbox(b[i + 4*((c + i) & 3)]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            sub_shift[127 - 8*i -: 8] = t[i];
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, s;
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            s  = a0 ^ a1 ^ a2 ^ a3;
            mixed[127 - 32*c -: 8]  = a0 ^ s ^ xtime(a0 ^ a1);
            mixed[119 - 32*c -: 8]  = a1 ^ s ^ xtime(a1 ^ a2);
            mixed[111 - 32*c -: 8]  = a2 ^ s ^ xtime(a2 ^ a3);
            mixed[103 - 32*c -: 8]  = a3 ^ s ^ xtime(a3 ^ a0);
        end
        // Expand the next round key from the current one.
        w0  = rkey_reg[127:96];
        w1  = rkey_reg[95:64];
        w2  = rkey_reg[63:32];
        w3  = rkey_reg[31:0];
        rot = {sbox(w3[23:16]) ^ rcon_reg, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        next_key[127:96] = w0 ^ rot;
        next_key[95:64]  = w1 ^ w0 ^ rot;
        next_key[63:32]  = w2 ^ w1 ^ w0 ^ rot;
        next_key[31:0]   = w3 ^ w2 ^ w1 ^ w0 ^ rot;
        round_out = ((round_reg == 4'(AES_ROUNDS)) ? sub_shift : mixed) ^ next_key;
    end

    always_comb begin
        state_next = state_reg;
        rkey_next  = rkey_reg;
        rcon_next  = rcon_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start) begin
            state_next = req.text ^ key;
            rkey_next  = key;
            rcon_next  = 8'h01;
            round_next = 4'd1;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            state_next = round_out;
            rkey_next  = next_key;
            rcon_next  = xtime(rcon_reg);
            round_next = round_reg + 4'd1;
            if (round_reg == 4'(AES_ROUNDS)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        rcon_reg  <= rcon_next;
    end

    assign rsp.done = done_reg;
    assign rsp.text = state_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without a running cipher");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg) else $error("cipher started while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("done held longer than one cycle");
`endif

endmodule

/* hw/rtl/aes_cmac_128_engine.sv */
// Top level of the AES-CMAC-128 tag engine.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_mode, s_data_byte
//  m_        out        m_valid / m_ready   m_tag_high, m_tag_low
//  apb       in         psel/penable/pready key_high (0x0), key_low (0x8)
//
// A byte is taken while the engine is idle; the byte after a full block starts
// the round-iterative cipher folding that block (one AES round per cycle), and
// no byte is taken until the fold ends. Finish runs a cipher pass for L, one or
// two doublings, a byte-serial pass to mask and pad the last block, a second pass.
// Reset clears the chain, fill count and control state; the buffer needs none.
// A stalled tag holds the output register; new bytes are taken meanwhile.
module aes_cmac_128_engine
    import acmac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_tag_high,
    output logic [63:0] m_tag_low,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_FOLD, ST_LKEY, ST_DBL, ST_LAST, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [63:0] key_high_reg, key_low_reg;
    block_t      chain_reg;
    logic [7:0]  buf_mem [BLOCK_BYTES];
    logic [4:0]  fill_reg;
    logic [3:0]  idx_reg;
    logic [7:0]  pend_byte_reg;
    block_t      sub_reg;
    logic [1:0]  dbl_cnt_reg;
    logic [7:0]  rd_byte_reg;
    logic        out_valid_reg;
    logic [63:0] out_high_reg, out_low_reg;
    block_t      tag_hold_reg;
    logic        tag_ready_reg;

    aes_req_t    aes_req;
    aes_rsp_t    aes_rsp;
    logic        s_take, m_take, cfg_wr;
    logic        tag_load;
    logic [7:0]  last_byte;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == ADDR_KEY_LOW) ? key_low_reg : key_high_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_take  = s_valid && s_ready;
    assign m_take  = out_valid_reg && m_ready;
    assign m_valid = out_valid_reg;
    assign m_tag_high = out_high_reg;
    assign m_tag_low  = out_low_reg;
    assign tag_load = (state_reg == ST_OUT) && (aes_rsp.done || tag_ready_reg)
                      && (!out_valid_reg || m_ready);

    acmac_aes_core u_aes (
        .aclk    (aclk),
        .aresetn (aresetn),
        .key     ({key_high_reg, key_low_reg}),
        .req     (aes_req),
        .rsp     (aes_rsp)
    );

    // Byte idx of the padded last block: stored byte, pad marker or zero.
    always_comb begin
        if (5'(idx_reg) < fill_reg) begin
            last_byte = rd_byte_reg;
        end else if (5'(idx_reg) == fill_reg) begin
            last_byte = PAD_BYTE;
        end else begin
            last_byte = 8'h00;
        end
    end

    always_comb begin
        aes_req.start = 1'b0;
        aes_req.text  = '0;
        if (s_take && s_mode == MODE_ABSORB && fill_reg == 5'(BLOCK_BYTES)) begin
            aes_req.start = 1'b1;
            for (int i = 0; i < BLOCK_BYTES; i++) begin
                aes_req.text[127 - 8*i -: 8] = buf_mem[i];
            end
            aes_req.text = aes_req.text ^ chain_reg;
        end else if (s_take && s_mode == MODE_FINISH) begin
            aes_req.start = 1'b1;
        end else if (state_reg == ST_LAST && idx_reg == 4'(BLOCK_BYTES - 1)
                     && dbl_cnt_reg == 2'd3) begin
            // Last rotation brings the masked block back into byte order.
            aes_req.start = 1'b1;
            aes_req.text  = chain_reg ^ {sub_reg[119:0], sub_reg[127:120] ^ last_byte};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_wr) begin
            if (paddr[3] == ADDR_KEY_HIGH) key_high_reg <= pwdata;
            else                           key_low_reg  <= pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take && s_mode == MODE_ABSORB) begin
            buf_mem[fill_reg[4] ? 4'd0 : fill_reg[3:0]] <= s_data_byte;
        end
        rd_byte_reg <= buf_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chain_reg     <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            dbl_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (tag_load) out_valid_reg <= 1'b1;
            else if (m_take) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_take && s_mode == MODE_ABSORB) begin
                        if (fill_reg == 5'(BLOCK_BYTES)) begin
                            fill_reg  <= 5'd1;
                            state_reg <= ST_FOLD;
                        end else begin
                            fill_reg <= fill_reg + 5'd1;
                        end
                    end else if (s_take) begin
                        state_reg <= ST_LKEY;
                    end
                end
                ST_FOLD: begin
                    if (aes_rsp.done) begin
                        chain_reg <= aes_rsp.text;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_LKEY: begin
                    if (aes_rsp.done) begin
                        sub_reg     <= aes_rsp.text;
                        dbl_cnt_reg <= (fill_reg == 5'(BLOCK_BYTES)) ? 2'd1 : 2'd0;
                        state_reg   <= ST_DBL;
                    end
                end
                ST_DBL: begin
                    // Double in GF(2^128); a full block stops after one pass.
                    sub_reg <= {sub_reg[126:0], 1'b0} ^ (sub_reg[127] ? 128'(GF_POLY) : '0);
                    if (dbl_cnt_reg == 2'd1) begin
                        dbl_cnt_reg <= 2'd2;
                        idx_reg     <= '0;
                        state_reg   <= ST_LAST;
                    end else begin
                        dbl_cnt_reg <= dbl_cnt_reg + 2'd1;
                    end
                end
                ST_LAST: begin
                    // Byte-serial pass: rotate the subkey, xor in the padded block.
                    if (dbl_cnt_reg == 2'd2) begin
                        dbl_cnt_reg <= 2'd3;
                    end else if (idx_reg == 4'(BLOCK_BYTES - 1)) begin
                        fill_reg    <= '0;
                        chain_reg   <= '0;
                        idx_reg     <= '0;
                        dbl_cnt_reg <= '0;
                        state_reg   <= ST_OUT;
                    end else begin
                        sub_reg <= {sub_reg[119:0], sub_reg[127:120] ^ last_byte};
                        idx_reg <= idx_reg + 4'd1;
                        dbl_cnt_reg <= 2'd2;
                    end
                end
                ST_OUT: begin
                    if (tag_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Hold the tag until a stalled output clears.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_ready_reg <= 1'b0;
        end else if (state_reg == ST_OUT && aes_rsp.done) begin
            tag_ready_reg <= 1'b1;
        end else if (state_reg != ST_OUT) begin
            tag_ready_reg <= 1'b0;
        end
        if (state_reg == ST_OUT && aes_rsp.done) tag_hold_reg <= aes_rsp.text;
    end

    always_ff @(posedge aclk) begin
        if (tag_load) begin
            {out_high_reg, out_low_reg} <= aes_rsp.done ? aes_rsp.text : tag_hold_reg;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 5'(BLOCK_BYTES)) else $error("fill count beyond one block");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_high_reg))
        else $error("tag changed while stalled");
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_take) else $error("request taken while busy");
`endif

endmodule
